// ----- sv/psda_pkg.sv -----
// Package with shared constants, types and functions of the polarization block.
`timescale 1ns / 1ps
package psda_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int PRESCALE     = 20;
    localparam int ANG_W        = 34;
    localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(64'd90  << 24);
    localparam logic [ANG_W-1:0] ANG_45  = ANG_W'(64'd45  << 24);
    localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(64'd180 << 24);
    localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(64'd360 << 24);
    localparam logic [13:0] AOP_WRAP = 14'd11520;

    function automatic logic [31:0] atan_q24(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'd754974720;
                1: v = 32'd445687602;
                2: v = 32'd235489088;
                3: v = 32'd119537938;
                4: v = 32'd60000934;
                5: v = 32'd30029717;
                6: v = 32'd15018523;
                7: v = 32'd7509720;
                8: v = 32'd3754917;
                9: v = 32'd1877466;
                10: v = 32'd938734;
                11: v = 32'd469367;
                12: v = 32'd234684;
                13: v = 32'd117342;
                14: v = 32'd58671;
                15: v = 32'd29335;
                16: v = 32'd14668;
                17: v = 32'd7334;
                18: v = 32'd3667;
                19: v = 32'd1833;
                20: v = 32'd917;
                21: v = 32'd458;
                22: v = 32'd229;
                23: v = 32'd115;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic [1:0] quad;
        logic       force_zero;
        logic       is_zero_y;
        logic       is_zero_x;
        logic       is_eq;
    } t_ang_ctl;

endpackage

// ----- sv/psda_cordic.sv -----
// Pipelined vectoring CORDIC giving the angle of a nonnegative vector in Q.24 degrees.
`timescale 1ns / 1ps
module psda_cordic #(
    parameter int MAG_W = 17,
    parameter int TAG_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [MAG_W-1:0]              i_x,
    input  logic [MAG_W-1:0]              i_y,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_valid,
    output logic [psda_pkg::ANG_W-1:0]    o_z,
    output logic [TAG_W-1:0]              o_tag
);
    import psda_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int DW = MAG_W + PRESCALE + 3;

    logic signed [DW-1:0]     r_x [N+1];
    logic signed [DW-1:0]     r_y [N+1];
    logic signed [ANG_W-1:0]  r_z [N+1];
    logic [TAG_W-1:0]         r_tag [N+1];
    logic [N:0]               r_vld;

    always_comb begin
        r_x[0]   = DW'(i_x) <<< PRESCALE;
        r_y[0]   = DW'(i_y) <<< PRESCALE;
        r_z[0]   = '0;
        r_tag[0] = i_tag;
        r_vld[0] = i_valid;
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic signed [DW-1:0]    n_x, n_y;
        logic signed [ANG_W-1:0] n_z;
        always_comb begin
            if (!r_y[g][DW-1]) begin
                n_x = r_x[g] + (r_y[g] >>> g);
                n_y = r_y[g] - (r_x[g] >>> g);
                n_z = r_z[g] + ANG_W'(atan_q24(g));
            end else begin
                n_x = r_x[g] - (r_y[g] >>> g);
                n_y = r_y[g] + (r_x[g] >>> g);
                n_z = r_z[g] - ANG_W'(atan_q24(g));
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_x[g+1]   <= n_x;
                r_y[g+1]   <= n_y;
                r_z[g+1]   <= n_z;
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_z     = r_z[N];
    assign o_tag   = r_tag[N];
endmodule

// ----- sv/psda_dop.sv -----
// Pipelined DoP: squared magnitude, restoring square root, then restoring division.
`timescale 1ns / 1ps
module psda_dop #(
    parameter int MAG_W = 17,
    parameter int SUM_W = 18
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MAG_W-1:0]  i_x,
    input  logic [MAG_W-1:0]  i_y,
    input  logic [SUM_W-1:0]  i_sum,
    output logic [15:0]       o_dop
);
    import psda_pkg::*;

    // m < 2^(2*MAG_W+1); n = m << 30; root has RW bits
    localparam int NW = 2*MAG_W + 1 + 30 + 1;
    localparam int NE = NW + (NW % 2);
    localparam int RW = NE / 2;
    localparam int QW = 17;
    localparam int DVW = RW + 1;

    // stage 0: squares
    logic [2*MAG_W:0] r_m;
    logic [SUM_W-1:0] r_s0;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m  <= (2*MAG_W+1)'(i_x) * (2*MAG_W+1)'(i_x)
                  + (2*MAG_W+1)'(i_y) * (2*MAG_W+1)'(i_y);
            r_s0 <= i_sum;
        end
    end

    // square root: one result bit per stage
    logic [NE-1:0]    r_rem [RW+1];
    logic [RW-1:0]    r_root [RW+1];
    logic [NE-1:0]    r_n [RW+1];
    logic [SUM_W-1:0] r_sq [RW+1];

    always_comb begin
        r_n[0]    = NE'(r_m) << 30;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_sq[0]   = r_s0;
    end

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        logic [RW+1:0] n_rem2;
        logic [RW+1:0] n_trial;
        logic          n_ok;
        always_comb begin
            n_rem2  = {r_rem[g][RW-1:0], r_n[g][NE-1-2*g -: 2]};
            n_trial = {r_root[g], 2'b01};
            n_ok    = n_rem2 >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= NE'(n_ok ? n_rem2 - n_trial : n_rem2);
                r_root[g+1] <= {r_root[g][RW-2:0], n_ok};
                r_n[g+1]    <= r_n[g];
                r_sq[g+1]   <= r_sq[g];
            end
        end
    end

    // division: root / sum, quotient fits QW bits, so the root bits above QW
    // preload the partial remainder
    logic [DVW+QW-1:0] r_num [QW+1];
    logic [SUM_W-1:0]  r_den [QW+1];
    logic [DVW-1:0]    r_dr  [QW+1];
    logic [QW-1:0]     r_q   [QW+1];

    always_comb begin
        r_num[0] = (DVW+QW)'(r_root[RW]);
        r_den[0] = r_sq[RW];
        r_dr[0]  = DVW'(r_root[RW] >> QW);
        r_q[0]   = '0;
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        logic [DVW:0] n_t;
        logic         n_ok;
        always_comb begin
            n_t  = {r_dr[g], r_num[g][QW-1-g]};
            n_ok = (r_den[g] != '0) && (n_t >= (DVW+1)'(r_den[g]));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dr[g+1]  <= DVW'(n_ok ? n_t - (DVW+1)'(r_den[g]) : n_t);
                r_q[g+1]   <= {r_q[g][QW-2:0], n_ok};
                r_num[g+1] <= r_num[g];
                r_den[g+1] <= r_den[g];
            end
        end
    end

    assign o_dop = 16'(r_q[QW]);
endmodule

// ----- sv/polarization_stokes_dop_aop_top.sv -----
// Top level of the polarization super-pixel Stokes, DoP and AoP pipeline.
//
// Channel  Dir  tdata fields (low bit up)
// s_axis   in   pix_deg0, pix_deg45, pix_deg90, pix_deg135
// m_axis   out  s0_doubled, s1, s2, dop, aop, s0_zero
//
// One super-pixel per cycle enters unless the output stalls. At PIXEL_BITS = 8 a
// result passes 44 register stages: input, 24 CORDIC, 18 alignment, output; the
// DoP side spans the same 42 middle stages as 1 square, 24 root and 17 divide stages.
// Reset clears all valid bits. A stall at the output freezes the whole pipeline
// when its last stage holds a result, and otherwise lets it advance to fill bubbles.
`timescale 1ns / 1ps
module polarization_stokes_dop_aop_top #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pix_deg0, pix_deg45, pix_deg90, pix_deg135
    input  logic [4*PIXEL_BITS+((8-((4*PIXEL_BITS)%8))%8)-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // s0_doubled, s1, s2, dop, aop, s0_zero
    output logic [63:0]           m_axis_tdata
);
    import psda_pkg::*;

    localparam int PB    = PIXEL_BITS;
    localparam int SUM_W = PB + 2;
    localparam int MAG_W = PB;
    localparam int NW    = 2*MAG_W + 1 + 30 + 1;
    localparam int RW    = (NW + (NW % 2)) / 2;
    localparam int DLAT  = 1 + RW + 17;
    localparam int ALAT  = CORDIC_STEPS;
    localparam int PAD   = (DLAT > ALAT) ? DLAT - ALAT : 0;

    logic en;
    logic r_ovld;
    assign en = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: differences and sum
    logic r_v1;
    logic [SUM_W-1:0] r_sum;
    logic signed [PB:0] r_d1, r_d2;
    logic [MAG_W-1:0] r_ax, r_ay;
    logic [PB-1:0] p0, p45, p90, p135;
    assign p0   = s_axis_tdata[0*PB +: PB];
    assign p45  = s_axis_tdata[1*PB +: PB];
    assign p90  = s_axis_tdata[2*PB +: PB];
    assign p135 = s_axis_tdata[3*PB +: PB];

    logic signed [PB:0] n_d1, n_d2;
    assign n_d1 = $signed({1'b0, p0}) - $signed({1'b0, p90});
    assign n_d2 = $signed({1'b0, p45}) - $signed({1'b0, p135});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (en) begin
            r_sum <= SUM_W'(p0) + SUM_W'(p45) + SUM_W'(p90) + SUM_W'(p135);
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_ax  <= MAG_W'(n_d1[PB] ? -n_d1 : n_d1);
            r_ay  <= MAG_W'(n_d2[PB] ? -n_d2 : n_d2);
        end
    end

    // tag carried along the CORDIC
    localparam int TAG_W = SUM_W + 2*(PB+1) + $bits(t_ang_ctl);
    t_ang_ctl ctl;
    always_comb begin
        ctl.quad       = {r_d2[PB], r_d1[PB]};
        ctl.force_zero = (r_d1 == '0) && (r_d2 == '0);
        ctl.is_zero_y  = (r_ay == '0);
        ctl.is_zero_x  = (r_ax == '0);
        ctl.is_eq      = (r_ax == r_ay);
    end

    logic                  c_vld;
    logic [ANG_W-1:0]      c_z;
    logic [TAG_W-1:0]      c_tag;
    psda_cordic #(.MAG_W(MAG_W), .TAG_W(TAG_W)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_x     (r_ax),
        .i_y     (r_ay),
        .i_tag   ({ctl, r_d2, r_d1, r_sum}),
        .o_valid (c_vld),
        .o_z     (c_z),
        .o_tag   (c_tag)
    );

    logic [15:0] dop_w;
    psda_dop #(.MAG_W(MAG_W), .SUM_W(SUM_W)) u_dop (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_ax),
        .i_y    (r_ay),
        .i_sum  (r_sum),
        .o_dop  (dop_w)
    );

    // align CORDIC output with DoP
    logic [ANG_W-1:0] r_pz [PAD+1];
    logic [TAG_W-1:0] r_pt [PAD+1];
    logic [PAD:0]     r_pv;
    always_comb begin
        r_pz[0] = c_z;
        r_pt[0] = c_tag;
        r_pv[0] = c_vld;
    end
    for (genvar g = 0; g < PAD; g++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[g+1] <= 1'b0;
            end else if (en) begin
                r_pv[g+1] <= r_pv[g];
            end
            if (en) begin
                r_pz[g+1] <= r_pz[g];
                r_pt[g+1] <= r_pt[g];
            end
        end
    end

    // final stage: clamp, quadrant, round, wrap
    t_ang_ctl         fc;
    logic [SUM_W-1:0] f_sum;
    logic [PB:0]      f_d1, f_d2;
    logic signed [ANG_W-1:0] zs;
    logic [ANG_W-1:0] a, th;
    logic [ANG_W-1:0] rnd;
    logic [13:0]      aop_w;
    assign {fc, f_d2, f_d1, f_sum} = r_pt[PAD];
    assign zs = $signed(r_pz[PAD]);

    always_comb begin
        if (fc.is_zero_y)       a = '0;
        else if (fc.is_zero_x)  a = ANG_90;
        else if (fc.is_eq)      a = ANG_45;
        else if (zs < 0)        a = '0;
        else if (zs > $signed(ANG_90)) a = ANG_90;
        else                    a = r_pz[PAD];
        unique case (fc.quad)
            2'b00:   th = a;
            2'b01:   th = ANG_180 - a;
            2'b11:   th = ANG_180 + a;
            default: th = ANG_360 - a;
        endcase
        rnd = (th + ANG_W'(1 << 18)) >> 19;
        aop_w = 14'(rnd);
        if (aop_w >= AOP_WRAP) aop_w = aop_w - AOP_WRAP;
        if (fc.force_zero) aop_w = '0;
    end

    logic [9:0]  r_os0;
    logic [8:0]  r_os1, r_os2;
    logic [15:0] r_odop;
    logic [13:0] r_oaop;
    logic        r_ozero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_pv[PAD];
        end
        if (en) begin
            r_os0   <= 10'(f_sum);
            r_os1   <= 9'(f_d1);
            r_os2   <= 9'(f_d2);
            r_odop  <= (f_sum == '0) ? 16'd0 : dop_w;
            r_oaop  <= aop_w;
            r_ozero <= (f_sum == '0);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {5'd0, r_ozero, r_oaop, r_odop, r_os2, r_os1, r_os0};
endmodule
